@@ rtl/hvd_pkg.sv @@
// Shared constants, types and arithmetic helpers of the HMM Viterbi decoder.
package hvd_pkg;

    localparam int NUM_STATES  = 8;
    localparam int NUM_SYMBOLS = 16;
    localparam int MAX_LEN     = 64;

    localparam int STATE_W  = $clog2(NUM_STATES);
    localparam int SYM_W    = $clog2(NUM_SYMBOLS);
    localparam int T_W      = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int COST_W   = 16;
    localparam int METRIC_W = 24;

    localparam logic [COST_W-1:0]   COST_IMPOSSIBLE = '1;
    localparam logic [METRIC_W-1:0] METRIC_MAX      = '1;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TRANS = 2'd1,
        CMD_EMIS  = 2'd2,
        CMD_OBS   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              ok;
        logic [2:0]        row;
        logic [3:0]        column;
        logic [COST_W-1:0] cost;
        logic [3:0]        sym;
        logic              sym_ok;
        logic              eos;
    } hvd_item_t;

    function automatic logic [METRIC_W-1:0] cost_to_metric(input logic [COST_W-1:0] c);
        return (c == COST_IMPOSSIBLE) ? METRIC_MAX : {{(METRIC_W-COST_W){1'b0}}, c};
    endfunction

    function automatic logic [METRIC_W-1:0] sat_add(input logic [METRIC_W-1:0] a,
                                                    input logic [METRIC_W-1:0] b);
        logic [METRIC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[METRIC_W] ? METRIC_MAX : s[METRIC_W-1:0];
    endfunction

endpackage

@@ rtl/hvd_front.sv @@
// Input stage of the HMM Viterbi decoder: range checks and a two-entry queue.
module hvd_front
    import hvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [2:0]        row,
    input  logic [3:0]        column,
    input  logic [COST_W-1:0] cost,
    input  logic [3:0]        observed_symbol,
    input  logic              end_of_sequence,
    output logic              q_valid,
    output hvd_item_t         q_item,
    input  logic              q_pop
);

    hvd_item_t   item_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    hvd_item_t   new_item;
    logic        push;
    logic        pop;

    always_comb
    begin
        new_item.cmd    = cmd_t'(command);
        new_item.row    = row;
        new_item.column = column;
        new_item.cost   = cost;
        new_item.sym    = observed_symbol;
        new_item.sym_ok = int'(observed_symbol) < NUM_SYMBOLS;
        new_item.eos    = end_of_sequence;
        case (cmd_t'(command))
            CMD_START: new_item.ok = int'(row) < NUM_STATES;
            CMD_TRANS: new_item.ok = (int'(row) < NUM_STATES) && (int'(column) < NUM_STATES);
            CMD_EMIS:  new_item.ok = (int'(row) < NUM_STATES) && (int'(column) < NUM_SYMBOLS);
            default:   new_item.ok = 1'b1;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = item_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/hvd_back.sv @@
// Execution stage of the HMM Viterbi decoder: tables, ACS pipeline, traceback, output.
module hvd_back
    import hvd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  hvd_item_t           q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [T_W-1:0]      time_step,
    output logic [STATE_W-1:0]  best_state,
    output logic [METRIC_W-1:0] path_cost,
    output logic                truncated,
    output logic                last
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_OBS, ST_COMMIT, ST_SCAN, ST_TB_INIT, ST_TB, ST_EMIT_RD, ST_EMIT_LD
    } state_t;

    localparam int ROW_W = NUM_STATES * COST_W;
    localparam int BP_W  = NUM_STATES * STATE_W;

    state_t state_reg;

    // Tables and stores.
    logic [COST_W-1:0]  st_reg [NUM_STATES];
    logic [ROW_W-1:0]   tr_mem [NUM_STATES];
    logic [COST_W-1:0]  em_mem [NUM_STATES * NUM_SYMBOLS];
    logic [BP_W-1:0]    bp_mem [MAX_LEN];
    logic [STATE_W-1:0] path_mem [MAX_LEN];

    logic [ROW_W-1:0]   tr_rd;
    logic [COST_W-1:0]  em_rd;
    logic [BP_W-1:0]    bp_rd;
    logic [STATE_W-1:0] path_rd;

    logic [METRIC_W-1:0] pm_reg [NUM_STATES];
    logic [METRIC_W-1:0] new_pm_reg [NUM_STATES];
    logic [STATE_W-1:0]  bp_row_reg [NUM_STATES];

    logic [LEN_W-1:0]   seq_len_reg;
    logic               ovf_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic               sym_ok_reg;
    logic               eos_reg;

    logic [STATE_W-1:0] iss_s_reg;
    logic               iss_active_reg;
    logic               p1_v_reg;
    logic [STATE_W-1:0] p1_s_reg;
    logic               p2_v_reg;
    logic [STATE_W-1:0] p2_s_reg;
    logic [METRIC_W-1:0] p2_cost_reg;
    logic [STATE_W-1:0] p2_bp_reg;
    logic [COST_W-1:0]  p2_em_reg;
    logic               p2_sym_ok_reg;

    logic [STATE_W-1:0]  scan_cnt_reg;
    logic [METRIC_W-1:0] min_reg;
    logic [STATE_W-1:0]  best_reg;
    logic [STATE_W-1:0]  cur_reg;
    logic [T_W-1:0]      tb_t_reg;
    logic [T_W-1:0]      em_t_reg;

    logic [METRIC_W-1:0] acs_cost;
    logic [STATE_W-1:0]  acs_bp;
    logic [BP_W-1:0]     bp_row_flat;
    logic [STATE_W-1:0]  tb_prev;
    logic [T_W-1:0]      len_m1;
    logic [T_W-1:0]      bp_raddr;
    logic                pw_en;
    logic [T_W-1:0]      pw_addr;
    logic [STATE_W-1:0]  pw_data;
    logic                ld_en;
    logic                out_free;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign ld_en    = q_pop && q_item.ok;
    assign len_m1   = T_W'(seq_len_reg - 1'b1);
    assign tb_prev  = bp_rd[cur_reg*STATE_W +: STATE_W];
    assign out_free = !out_valid || out_ready;

    // Stage one: cheapest predecessor, lowest on ties; start cost on the first step.
    always_comb
    begin
        logic [METRIC_W-1:0] c;
        acs_cost = '0;
        acs_bp   = '0;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            c = sat_add(pm_reg[i], cost_to_metric(tr_rd[i*COST_W +: COST_W]));
            if (i == 0 || c < acs_cost)
            begin
                acs_cost = c;
                acs_bp   = STATE_W'(i);
            end
        end
        if (seq_len_reg == '0)
        begin
            acs_cost = cost_to_metric(st_reg[p1_s_reg]);
            acs_bp   = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_STATES; i++)
        begin
            bp_row_flat[i*STATE_W +: STATE_W] = bp_row_reg[i];
        end
    end

    always_comb
    begin
        bp_raddr = tb_t_reg - 1'b1;
        pw_en    = 1'b0;
        pw_addr  = len_m1;
        pw_data  = best_reg;
        case (state_reg)
            ST_TB_INIT:
            begin
                bp_raddr = len_m1;
                pw_en    = 1'b1;
            end
            ST_TB:
            begin
                pw_en   = 1'b1;
                pw_addr = tb_t_reg - 1'b1;
                pw_data = tb_prev;
            end
            default:
            begin
                pw_en = 1'b0;
            end
        endcase
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (ld_en && q_item.cmd == CMD_START)
        begin
            st_reg[q_item.row[STATE_W-1:0]] <= q_item.cost;
        end
        if (ld_en && q_item.cmd == CMD_TRANS)
        begin
            tr_mem[q_item.column[STATE_W-1:0]][q_item.row[STATE_W-1:0]*COST_W +: COST_W]
                <= q_item.cost;
        end
        tr_rd <= tr_mem[iss_s_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ld_en && q_item.cmd == CMD_EMIS)
        begin
            em_mem[{q_item.row[STATE_W-1:0], q_item.column[SYM_W-1:0]}] <= q_item.cost;
        end
        em_rd <= em_mem[{iss_s_reg, sym_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COMMIT)
        begin
            bp_mem[seq_len_reg[T_W-1:0]] <= bp_row_flat;
        end
        bp_rd <= bp_mem[bp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            path_mem[pw_addr] <= pw_data;
        end
        path_rd <= path_mem[em_t_reg];
    end

    // Sequencer, pipeline and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seq_len_reg    <= '0;
            ovf_reg        <= 1'b0;
            sym_reg        <= '0;
            sym_ok_reg     <= 1'b0;
            eos_reg        <= 1'b0;
            iss_s_reg      <= '0;
            iss_active_reg <= 1'b0;
            p1_v_reg       <= 1'b0;
            p1_s_reg       <= '0;
            p2_v_reg       <= 1'b0;
            p2_s_reg       <= '0;
            p2_cost_reg    <= '0;
            p2_bp_reg      <= '0;
            p2_em_reg      <= '0;
            p2_sym_ok_reg  <= 1'b0;
            scan_cnt_reg   <= '0;
            min_reg        <= '0;
            best_reg       <= '0;
            cur_reg        <= '0;
            tb_t_reg       <= '0;
            em_t_reg       <= '0;
            out_valid      <= 1'b0;
            time_step      <= '0;
            best_state     <= '0;
            path_cost      <= '0;
            truncated      <= 1'b0;
            last           <= 1'b0;
            for (int i = 0; i < NUM_STATES; i++)
            begin
                pm_reg[i]     <= '0;
                new_pm_reg[i] <= '0;
                bp_row_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end

            p1_v_reg      <= iss_active_reg;
            p1_s_reg      <= iss_s_reg;
            p2_v_reg      <= p1_v_reg;
            p2_s_reg      <= p1_s_reg;
            p2_cost_reg   <= acs_cost;
            p2_bp_reg     <= acs_bp;
            p2_em_reg     <= em_rd;
            p2_sym_ok_reg <= sym_ok_reg;

            if (iss_active_reg)
            begin
                iss_s_reg <= iss_s_reg + 1'b1;
                if (int'(iss_s_reg) == NUM_STATES - 1)
                begin
                    iss_active_reg <= 1'b0;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_item.cmd == CMD_OBS)
                    begin
                        eos_reg <= q_item.eos;
                        if (int'(seq_len_reg) >= MAX_LEN)
                        begin
                            ovf_reg <= 1'b1;
                            if (q_item.eos)
                            begin
                                scan_cnt_reg <= '0;
                                state_reg    <= ST_SCAN;
                            end
                        end
                        else
                        begin
                            sym_reg        <= q_item.sym[SYM_W-1:0];
                            sym_ok_reg     <= q_item.sym_ok;
                            iss_s_reg      <= '0;
                            iss_active_reg <= 1'b1;
                            state_reg      <= ST_OBS;
                        end
                    end
                end
                ST_OBS:
                begin
                    if (p2_v_reg)
                    begin
                        new_pm_reg[p2_s_reg] <= sat_add(p2_cost_reg, p2_sym_ok_reg ?
                            cost_to_metric(p2_em_reg) : METRIC_MAX);
                        bp_row_reg[p2_s_reg] <= p2_bp_reg;
                        if (int'(p2_s_reg) == NUM_STATES - 1)
                        begin
                            state_reg <= ST_COMMIT;
                        end
                    end
                end
                ST_COMMIT:
                begin
                    for (int i = 0; i < NUM_STATES; i++)
                    begin
                        pm_reg[i] <= new_pm_reg[i];
                    end
                    seq_len_reg  <= seq_len_reg + 1'b1;
                    scan_cnt_reg <= '0;
                    state_reg    <= eos_reg ? ST_SCAN : ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (scan_cnt_reg == '0 || pm_reg[scan_cnt_reg] < min_reg)
                    begin
                        min_reg  <= pm_reg[scan_cnt_reg];
                        best_reg <= scan_cnt_reg;
                    end
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (int'(scan_cnt_reg) == NUM_STATES - 1)
                    begin
                        state_reg <= ST_TB_INIT;
                    end
                end
                ST_TB_INIT:
                begin
                    cur_reg  <= best_reg;
                    tb_t_reg <= len_m1;
                    em_t_reg <= '0;
                    state_reg <= (len_m1 == '0) ? ST_EMIT_RD : ST_TB;
                end
                ST_TB:
                begin
                    cur_reg  <= tb_prev;
                    tb_t_reg <= tb_t_reg - 1'b1;
                    if (tb_t_reg == T_W'(1))
                    begin
                        state_reg <= ST_EMIT_RD;
                    end
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_LD;
                end
                ST_EMIT_LD:
                begin
                    if (out_free)
                    begin
                        out_valid  <= 1'b1;
                        time_step  <= em_t_reg;
                        best_state <= path_rd;
                        path_cost  <= min_reg;
                        truncated  <= ovf_reg;
                        last       <= (em_t_reg == len_m1);
                        if (em_t_reg == len_m1)
                        begin
                            seq_len_reg <= '0;
                            ovf_reg     <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            em_t_reg  <= em_t_reg + 1'b1;
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_obs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OBS) |-> (int'(seq_len_reg) < MAX_LEN))
        else $error("ACS pass started with a full sequence");
    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        p2_v_reg |-> $past(p1_v_reg))
        else $error("ACS stage two valid without stage one");
    a_tb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TB) |-> (tb_t_reg != '0))
        else $error("Traceback ran past time step zero");
    a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_LD) |-> (seq_len_reg != '0))
        else $error("Path emitted for an empty sequence");
`endif

endmodule

@@ rtl/hmm_viterbi_decoder_unit.sv @@
// Top level of the HMM Viterbi decoder.
//
// Input channel (in_valid/in_ready): each transaction is a command. Commands 0 to 2
// load start, transition and emission costs (unsigned 8.8, 65535 is impossible);
// command 3 is an observation, and end_of_sequence marks the last one of a sequence.
// Output channel (out_valid/out_ready): after the final observation the decoded path
// comes out in time order, one transaction per time step, last set on the final one.
// A load is written in the back end as it is taken from the queue. An observation is
// taken from the queue, then eight destination states go one per cycle through a
// three-stage add-compare-select pipeline, and the metrics are committed.
// The final observation adds a scan for the cheapest end state, traceback through
// the backpointer memory and the emission of each path step through the path memory.
// A two-entry queue sits between input and execution, so up to two input transactions
// are taken while the back end computes or while a result waits on a stalled receiver.
// Reset empties the queue and clears the sequence length and overflow flag; the cost
// tables hold nothing defined until loaded. Observations beyond 64 are dropped and
// reported through truncated.
module hmm_viterbi_decoder_unit
    import hvd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [2:0]          row,
    input  logic [3:0]          column,
    input  logic [COST_W-1:0]   cost,
    input  logic [3:0]          observed_symbol,
    input  logic                end_of_sequence,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [T_W-1:0]      time_step,
    output logic [STATE_W-1:0]  best_state,
    output logic [METRIC_W-1:0] path_cost,
    output logic                truncated,
    output logic                last
);

    logic      q_valid;
    hvd_item_t q_item;
    logic      q_pop;

    hvd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .row             (row),
        .column          (column),
        .cost            (cost),
        .observed_symbol (observed_symbol),
        .end_of_sequence (end_of_sequence),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    hvd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .time_step  (time_step),
        .best_state (best_state),
        .path_cost  (path_cost),
        .truncated  (truncated),
        .last       (last)
    );

endmodule

@@ tb/tb_hmm_viterbi_decoder_unit.sv @@
// Self-checking testbench for the HMM Viterbi decoder unit.
module tb_hmm_viterbi_decoder_unit;
    import hvd_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [2:0]  row;
        logic [3:0]  col;
        logic [15:0] cst;
        logic [3:0]  sym;
        logic        eos;
        logic        typed;
        logic [2:0]  t_state;
        logic [23:0] t_cost;
    } stim_row_t;

    typedef struct {
        logic [5:0]  step;
        logic [2:0]  state;
        logic [23:0] pcost;
        logic        trunc;
        logic        fin;
    } path_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [2:0]  row = '0;
    logic [3:0]  column = '0;
    logic [15:0] cost = '0;
    logic [3:0]  observed_symbol = '0;
    logic        end_of_sequence = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  time_step;
    logic [2:0]  best_state;
    logic [23:0] path_cost;
    logic        truncated;
    logic        last;

    hmm_viterbi_decoder_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .row(row), .column(column), .cost(cost),
        .observed_symbol(observed_symbol), .end_of_sequence(end_of_sequence),
        .out_valid(out_valid), .out_ready(out_ready), .time_step(time_step),
        .best_state(best_state), .path_cost(path_cost), .truncated(truncated),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state.
    logic [15:0] start_tbl [8];
    logic [15:0] trans_tbl [64];
    logic [15:0] emis_tbl [128];
    logic [23:0] metric [8];
    logic [2:0]  backptr [64][8];
    int          seq_len;
    logic        dropped;
    path_entry_t decoded_path[$];
    path_entry_t expected_path[$];

    int errors = 0;
    int results_seen = 0;
    int sequences_done = 0;
    int items_sent = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int cycles = 0;

    function automatic logic [23:0] to_metric(logic [15:0] c);
        return (c == 16'hFFFF) ? 24'hFFFFFF : {8'h00, c};
    endfunction

    function automatic logic [23:0] add_sat(logic [23:0] a, logic [23:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[24] ? 24'hFFFFFF : s[23:0];
    endfunction

    // Applies one command to the predictor; a closing observation fills decoded_path.
    function automatic void decode_command(stim_row_t it);
        logic [23:0] next [8];
        logic [23:0] cand;
        logic [23:0] low;
        logic [2:0]  pick;
        logic [2:0]  path [64];
        path_entry_t pe;
        int          t;
        decoded_path.delete();
        case (it.cmd)
            CMD_START: start_tbl[it.row] = it.cst;
            CMD_TRANS: if (it.col < 8) trans_tbl[{it.row, it.col[2:0]}] = it.cst;
            CMD_EMIS:  emis_tbl[{it.row, it.col}] = it.cst;
            default:
            begin
                t = seq_len;
                if (t >= 64)
                    dropped = 1'b1;
                else
                begin
                    for (int s = 0; s < 8; s++)
                    begin
                        pick = 0;
                        low = to_metric(start_tbl[s]);
                        if (t > 0)
                            for (int i = 0; i < 8; i++)
                            begin
                                cand = add_sat(metric[i], to_metric(trans_tbl[i * 8 + s]));
                                if (i == 0 || cand < low)
                                begin
                                    low = cand;
                                    pick = i[2:0];
                                end
                            end
                        next[s] = add_sat(low, to_metric(emis_tbl[s * 16 + it.sym]));
                        backptr[t][s] = pick;
                    end
                    metric = next;
                    seq_len = t + 1;
                end
                if (it.eos)
                begin
                    pick = 0;
                    low = metric[0];
                    for (int s = 1; s < 8; s++)
                        if (metric[s] < low)
                        begin
                            low = metric[s];
                            pick = s[2:0];
                        end
                    path[seq_len - 1] = pick;
                    for (int k = seq_len - 1; k > 0; k--)
                        path[k - 1] = backptr[k][path[k]];
                    for (int k = 0; k < seq_len; k++)
                    begin
                        pe.step  = k[5:0];
                        pe.state = path[k];
                        pe.pcost = low;
                        pe.trunc = dropped;
                        pe.fin   = (k == seq_len - 1);
                        decoded_path = {decoded_path, pe};
                    end
                    seq_len = 0;
                    dropped = 1'b0;
                end
            end
        endcase
    endfunction

    task automatic send(stim_row_t it);
        path_entry_t pe;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= it.cmd;
        row <= it.row;
        column <= it.col;
        cost <= it.cst;
        observed_symbol <= it.sym;
        end_of_sequence <= it.eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        decode_command(it);
        if (it.typed)
        begin
            pe.step  = 6'd0;
            pe.state = it.t_state;
            pe.pcost = it.t_cost;
            pe.trunc = 1'b0;
            pe.fin   = 1'b1;
            expected_path = {expected_path, pe};
        end
        else
            expected_path = {expected_path, decoded_path};
        if (it.cmd == CMD_OBS && it.eos)
            sequences_done++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_path.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // The idle mix follows the count of random transactions sent so far.
    task automatic set_phase(int n);
        case ((n / 24) % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 74; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 74; end
            default: begin send_idle = 21; recv_stall = 21; end
        endcase
    endtask

    function automatic stim_row_t load_row(cmd_t c, int r, int col, int cst);
        return '{c, r[2:0], col[3:0], cst[15:0], 4'd0, 1'b0, 1'b0, 3'd0, 24'd0};
    endfunction

    function automatic stim_row_t obs_row(int sym, bit e);
        return '{CMD_OBS, 3'd0, 4'd0, 16'd0, sym[3:0], e, 1'b0, 3'd0, 24'd0};
    endfunction

    function automatic stim_row_t typed_obs(int sym, int st, int pc);
        return '{CMD_OBS, 3'd0, 4'd0, 16'd0, sym[3:0], 1'b1, 1'b1, st[2:0], pc[23:0]};
    endfunction

    // Observations use only these four symbols; the fill loads only their emission entries.
    function automatic int obs_sym(int k);
        case (k)
            0: return 0;
            1: return 3;
            2: return 5;
            default: return 15;
        endcase
    endfunction

    function automatic int rand_sym();
        return obs_sym($urandom_range(3));
    endfunction

    function automatic logic [15:0] rand_cost();
        case ($urandom_range(3))
            0: return 16'hFFFF;
            1: return $urandom_range(65535);
            default: return $urandom_range(3000);
        endcase
    endfunction

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        path_entry_t e;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (expected_path.size() == 0)
            begin
                $display("%0t: unexpected result step %0d state %0d cost %0d",
                         $time, time_step, best_state, path_cost);
                errors++;
            end
            else
            begin
                e = expected_path.pop_front();
                if (time_step !== e.step || best_state !== e.state || path_cost !== e.pcost
                    || truncated !== e.trunc || last !== e.fin)
                begin
                    $display("%0t: mismatch expected step %0d state %0d cost %0d trunc %0b last %0b",
                             $time, e.step, e.state, e.pcost, e.trunc, e.fin);
                    $display("%0t:          actual   step %0d state %0d cost %0d trunc %0b last %0b",
                             $time, time_step, best_state, path_cost, truncated, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("tb_hmm_viterbi_decoder_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed[$];
        stim_row_t it;
        int rand_items;
        int len;
        bit long_done;
        seq_len = 0;
        dropped = 1'b0;
        rand_items = 0;
        long_done = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every table entry that an observation can read.
        for (int s = 0; s < 8; s++)
            send(load_row(CMD_START, s, 0, 1000));
        for (int s = 0; s < 64; s++)
            send(load_row(CMD_TRANS, s / 8, s % 8, 256));
        for (int s = 0; s < 32; s++)
            send(load_row(CMD_EMIS, s / 4, obs_sym(s % 4), 512));

        directed = '{
            load_row(CMD_START, 1, 0, 0),
            load_row(CMD_EMIS, 1, 5, 0),
            typed_obs(5, 1, 0),
            '{CMD_START, 3'd2, 4'd0, 16'd0, 4'd0, 1'b1, 1'b0, 3'd0, 24'd0},
            typed_obs(5, 1, 0),
            load_row(CMD_EMIS, 1, 5, 512),
            typed_obs(5, 1, 512),
            load_row(CMD_START, 0, 0, 65535),
            load_row(CMD_EMIS, 0, 15, 65535),
            load_row(CMD_TRANS, 3, 9, 7),
            load_row(CMD_TRANS, 0, 0, 65535),
            load_row(CMD_TRANS, 7, 7, 0),
            obs_row(15, 0),
            obs_row(0, 0),
            obs_row(15, 1)
        };
        for (int s = 0; s < 8; s++)
            directed = {directed, load_row(CMD_EMIS, s, 3, 65535)};
        directed = {directed, typed_obs(3, 0, 24'hFFFFFF)};
        foreach (directed[k])
            send(directed[k]);
        // Hold the sender until every path has come back.
        drain();

        while (rand_items < 96)
        begin
            if ($urandom_range(99) < 25)
            begin
                set_phase(rand_items);
                it = load_row(cmd_t'($urandom_range(2)), $urandom_range(7),
                              $urandom_range(15), 0);
                it.cst = rand_cost();
                it.eos = $urandom_range(1);
                send(it);
                rand_items++;
            end
            else
            begin
                if (!long_done && rand_items > 10)
                begin
                    len = 67;
                    long_done = 1;
                end
                else if ($urandom_range(9) == 0)
                    len = $urandom_range(16, 8);
                else
                    len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++)
                begin
                    set_phase(rand_items);
                    send(obs_row(rand_sym(), k == len - 1));
                    rand_items++;
                end
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_path.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d transactions over %0d decoded sequences, one past the length limit;",
                 items_sent, sequences_done);
        $display("checked %0d path steps under four sender and receiver idle mixes.",
                 results_seen);
        if (errors == 0 && expected_path.size() == 0)
            $display("tb_hmm_viterbi_decoder_unit: PASS");
        else
            $display("tb_hmm_viterbi_decoder_unit: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/hvd_pkg.sv
rtl/hvd_front.sv
rtl/hvd_back.sv
rtl/hmm_viterbi_decoder_unit.sv
tb/tb_hmm_viterbi_decoder_unit.sv
